FILE: rtl/wrdd_pkg.sv
// Shared types and constants of the weighted region descriptor distance block.
package wrdd_pkg;

   localparam int ByteW    = 8;
   localparam int TermW    = 17;
   localparam int PosW     = 11;
   localparam int SumW     = 28;
   localparam int BgW      = SumW + 1;
   localparam int WeightW  = 16;
   localparam int ProdAW   = WeightW + SumW;
   localparam int ProdGW   = WeightW + BgW;
   localparam int DistW    = 44;
   localparam int CircW    = 6;
   localparam int RayW     = 5;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   localparam logic [PosW-1:0]  PosMax  = '1;
   localparam logic [SumW-1:0]  SumMax  = '1;
   localparam logic [DistW-1:0] DistMax = '1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ALPHA_POSITIONS = 3'd0,
      CSR_BETA_POSITIONS  = 3'd1,
      CSR_EXTENDED_MODE   = 3'd2,
      CSR_WEIGHT_ALPHA    = 3'd3,
      CSR_WEIGHT_GAMMA    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CircW-1:0]   alpha_positions;
      logic [RayW-1:0]    beta_positions;
      logic               extended_mode;
      logic [WeightW-1:0] weight_alpha;
      logic [WeightW-1:0] weight_gamma;
   } cfg_type;

   typedef struct packed {
      logic [TermW-1:0] term;
      logic             last;
   } term_type;

   typedef struct packed {
      logic [SumW-1:0] alpha;
      logic [BgW-1:0]  beta_gamma;
   } fin_type;

endpackage

FILE: rtl/wrdd_term.sv
// Input register and per-position mismatch term stage.
module wrdd_term (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wrdd_pkg::ByteW-1:0]    req_base_first,
   input  logic [wrdd_pkg::ByteW-1:0]    req_base_second,
   input  logic [wrdd_pkg::ByteW-1:0]    req_ext_first,
   input  logic [wrdd_pkg::ByteW-1:0]    req_ext_second,
   input  logic                          req_last,
   input  logic                          extended_mode,
   output logic                          term_valid,
   output wrdd_pkg::term_type            term,
   input  logic                          term_ready
);

   logic                       in_valid_ff;
   logic [wrdd_pkg::ByteW-1:0] b1_ff, b2_ff, e1_ff, e2_ff;
   logic                       last_ff;
   logic                       in_ready;
   logic                       term_valid_ff;
   wrdd_pkg::term_type         term_ff;
   wrdd_pkg::term_type         term_in;
   logic                       stage_ready;
   logic                       base_diff;
   logic                       ext_diff;
   logic [2*wrdd_pkg::ByteW-1:0] ext_prod;

   assign stage_ready = !term_valid_ff || term_ready;
   assign in_ready    = !in_valid_ff || stage_ready;
   assign req_stall   = !in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
      if (in_ready && req_valid) begin
         b1_ff   <= req_base_first;
         b2_ff   <= req_base_second;
         e1_ff   <= req_ext_first;
         e2_ff   <= req_ext_second;
         last_ff <= req_last;
      end
   end

   always_comb begin
      base_diff = (b1_ff != b2_ff);
      ext_diff  = (e1_ff != e2_ff);
      ext_prod  = e1_ff * e2_ff;
      term_in.last = last_ff;
      if (extended_mode) begin
         term_in.term = wrdd_pkg::TermW'(base_diff) + wrdd_pkg::TermW'(ext_diff)
                      + (base_diff ? {ext_prod, 1'b0} : '0);
      end else begin
         term_in.term = wrdd_pkg::TermW'(base_diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_valid_ff <= 1'b0;
      end else if (stage_ready) begin
         term_valid_ff <= in_valid_ff;
      end
      if (stage_ready && in_valid_ff) begin
         term_ff <= term_in;
      end
   end

   assign term_valid = term_valid_ff;
   assign term       = term_ff;

endmodule

FILE: rtl/wrdd_accum.sv
// Position counter, region accumulators and final-sum register.
module wrdd_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  wrdd_pkg::cfg_type             cfg,
   input  logic                          term_valid,
   input  wrdd_pkg::term_type            term,
   output logic                          term_ready,
   output logic                          fin_valid,
   output wrdd_pkg::fin_type             fin,
   input  logic                          fin_ready
);

   logic [wrdd_pkg::PosW-1:0] position_ff, position_in;
   logic [wrdd_pkg::SumW-1:0] alpha_ff, alpha_in;
   logic [wrdd_pkg::SumW-1:0] beta_ff, beta_in;
   logic [wrdd_pkg::SumW-1:0] gamma_ff, gamma_in;
   logic                      fin_valid_ff, fin_valid_in;
   wrdd_pkg::fin_type         fin_ff, fin_in;
   logic                      fin_slot_free;
   logic                      take;
   logic [wrdd_pkg::CircW:0]  beta_limit;
   logic [wrdd_pkg::SumW-1:0] alpha_new, beta_new, gamma_new;

   function automatic logic [wrdd_pkg::SumW-1:0] sat_add(
      input logic [wrdd_pkg::SumW-1:0]  acc,
      input logic [wrdd_pkg::TermW-1:0] value
   );
      logic [wrdd_pkg::SumW:0] s;
      s = {1'b0, acc} + (wrdd_pkg::SumW+1)'(value);
      return s[wrdd_pkg::SumW] ? wrdd_pkg::SumMax : s[wrdd_pkg::SumW-1:0];
   endfunction

   assign fin_slot_free = !fin_valid_ff || fin_ready;
   assign term_ready    = !term.last || fin_slot_free;
   assign take          = term_valid && term_ready;
   assign beta_limit    = {1'b0, cfg.alpha_positions}
                        + (wrdd_pkg::CircW+1)'(cfg.beta_positions);

   always_comb begin
      alpha_new = alpha_ff;
      beta_new  = beta_ff;
      gamma_new = gamma_ff;
      if (position_ff < wrdd_pkg::PosW'(cfg.alpha_positions)) begin
         alpha_new = sat_add(alpha_ff, term.term);
      end else if (position_ff < wrdd_pkg::PosW'(beta_limit)) begin
         beta_new = sat_add(beta_ff, term.term);
      end else begin
         gamma_new = sat_add(gamma_ff, term.term);
      end

      fin_in.alpha      = alpha_new;
      fin_in.beta_gamma = {1'b0, beta_new} + {1'b0, gamma_new};

      position_in  = position_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      gamma_in     = gamma_ff;
      fin_valid_in = fin_valid_ff && !fin_ready;
      if (take) begin
         if (term.last) begin
            position_in  = '0;
            alpha_in     = '0;
            beta_in      = '0;
            gamma_in     = '0;
            fin_valid_in = 1'b1;
         end else begin
            position_in = (position_ff == wrdd_pkg::PosMax) ? position_ff
                                                            : position_ff + 1'b1;
            alpha_in    = alpha_new;
            beta_in     = beta_new;
            gamma_in    = gamma_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         alpha_ff     <= '0;
         beta_ff      <= '0;
         gamma_ff     <= '0;
         fin_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         gamma_ff     <= gamma_in;
         fin_valid_ff <= fin_valid_in;
      end
      if (take && term.last) begin
         fin_ff <= fin_in;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

FILE: rtl/wrdd_weight.sv
// Weight multipliers and saturating result register.
module wrdd_weight (
   input  logic                          clock,
   input  logic                          reset,
   input  wrdd_pkg::cfg_type             cfg,
   input  logic                          fin_valid,
   input  wrdd_pkg::fin_type             fin,
   output logic                          fin_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wrdd_pkg::DistW-1:0]    rsp_distance
);

   logic                          prod_valid_ff;
   logic [wrdd_pkg::ProdAW-1:0]   prod_a_ff, prod_a_in;
   logic [wrdd_pkg::ProdGW-1:0]   prod_g_ff, prod_g_in;
   logic                          out_valid_ff;
   logic [wrdd_pkg::DistW-1:0]    dist_ff, dist_in;
   logic [wrdd_pkg::ProdGW:0]     total;
   logic                          out_ready;
   logic                          prod_ready;

   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign fin_ready  = prod_ready;

   assign prod_a_in = cfg.weight_alpha * fin.alpha;
   assign prod_g_in = cfg.weight_gamma * fin.beta_gamma;

   always_comb begin
      total = (wrdd_pkg::ProdGW+1)'(prod_a_ff) + (wrdd_pkg::ProdGW+1)'(prod_g_ff);
      if (total[wrdd_pkg::ProdGW:wrdd_pkg::DistW] != '0) begin
         dist_in = wrdd_pkg::DistMax;
      end else begin
         dist_in = total[wrdd_pkg::DistW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= fin_valid;
         end
         if (out_ready) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
      if (prod_ready && fin_valid) begin
         prod_a_ff <= prod_a_in;
         prod_g_ff <= prod_g_in;
      end
      if (out_ready && prod_valid_ff) begin
         dist_ff <= dist_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_distance = dist_ff;

endmodule

FILE: rtl/weighted_region_descriptor_distance.sv
// Top level of the weighted region descriptor distance block.
//
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  base_first, base_second, ext_first, ext_second, last
//  rsp      out        rsp_valid/rsp_stall  distance (one per transaction carrying last)
//  csr      in         csr_write            csr_index, csr_wdata
//
// One transaction is accepted per cycle unless req_stall is high; accumulators close a loop.
// The result passes the term, final-sum, product and result registers after last is accepted.
// Synchronous reset clears the position counter, the sums and all valid flags.
// A stall on rsp holds the result register; input is stalled only once every stage is full.
module weighted_region_descriptor_distance (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [wrdd_pkg::ByteW-1:0]       req_base_first,
   input  logic [wrdd_pkg::ByteW-1:0]       req_base_second,
   input  logic [wrdd_pkg::ByteW-1:0]       req_ext_first,
   input  logic [wrdd_pkg::ByteW-1:0]       req_ext_second,
   input  logic                             req_last,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [wrdd_pkg::DistW-1:0]       rsp_distance,
   input  logic                             csr_write,
   input  logic [wrdd_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [wrdd_pkg::CsrDataW-1:0]    csr_wdata
);

   wrdd_pkg::cfg_type  cfg_ff;
   logic               term_valid;
   wrdd_pkg::term_type term;
   logic               term_ready;
   logic               fin_valid;
   wrdd_pkg::fin_type  fin;
   logic               fin_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_positions <= wrdd_pkg::CircW'(1);
         cfg_ff.beta_positions  <= wrdd_pkg::RayW'(1);
         cfg_ff.extended_mode   <= 1'b0;
         cfg_ff.weight_alpha    <= wrdd_pkg::WeightW'(1280);
         cfg_ff.weight_gamma    <= wrdd_pkg::WeightW'(256);
      end else if (csr_write) begin
         case (wrdd_pkg::csr_index_type'(csr_index))
            wrdd_pkg::CSR_ALPHA_POSITIONS: begin
               cfg_ff.alpha_positions <= csr_wdata[wrdd_pkg::CircW-1:0];
            end
            wrdd_pkg::CSR_BETA_POSITIONS: begin
               cfg_ff.beta_positions <= csr_wdata[wrdd_pkg::RayW-1:0];
            end
            wrdd_pkg::CSR_EXTENDED_MODE: begin
               cfg_ff.extended_mode <= csr_wdata[0];
            end
            wrdd_pkg::CSR_WEIGHT_ALPHA: begin
               cfg_ff.weight_alpha <= csr_wdata[wrdd_pkg::WeightW-1:0];
            end
            wrdd_pkg::CSR_WEIGHT_GAMMA: begin
               cfg_ff.weight_gamma <= csr_wdata[wrdd_pkg::WeightW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   wrdd_term u_term (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_base_first  (req_base_first),
      .req_base_second (req_base_second),
      .req_ext_first   (req_ext_first),
      .req_ext_second  (req_ext_second),
      .req_last        (req_last),
      .extended_mode   (cfg_ff.extended_mode),
      .term_valid      (term_valid),
      .term            (term),
      .term_ready      (term_ready)
   );

   wrdd_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .term_valid (term_valid),
      .term       (term),
      .term_ready (term_ready),
      .fin_valid  (fin_valid),
      .fin        (fin),
      .fin_ready  (fin_ready)
   );

   wrdd_weight u_weight (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .fin_valid    (fin_valid),
      .fin          (fin),
      .fin_ready    (fin_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_distance (rsp_distance)
   );

   // Input backpressure only arises when the result register is full and stalled.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while result path can drain");

   // Only a transaction carrying last can be held back by the accumulator stage.
   a_hold_only_last: assert property (@(posedge clock) disable iff (reset)
      (term_valid && !term_ready) |-> term.last)
      else $error("non-last transaction held at the accumulator");

   // A final-sum entry waiting on the weight stage keeps its sums.
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (fin_valid && !fin_ready) |=> (fin_valid && $stable(fin)))
      else $error("final sums changed while waiting");

endmodule
